FILE: hw/rtl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Word types of the request and response channels and the frame status codes.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   // Frame status codes reported on the final word of a frame.
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH    = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED   = 2'd3;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_word_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_present;
      logic [3:0] frame_opcode;
      logic       last_of_frame;
      logic [1:0] frame_status;
   } rsp_word_type;

endpackage

FILE: hw/rtl/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Strips the header of masked WebSocket frames and unmasks the payload bytes.
// ----------------------------------------------------------------------------
// The block takes one raw frame byte per word and sustains one word per clock
// with no gaps while the response side keeps up. While a finished result waits
// on a stalled response channel, the input register can still take one more
// word before the request side is stalled. An accepted word waits in the input
// register while a stalled response channel holds a full output register;
// then its result is loaded into the output register, which drives the
// response port. The rate is set by the single header-state update, which
// reads and writes the parser state once per word. Header bytes other than a
// frame's last byte give no response word; every payload byte gives one, and
// the last byte of a frame always gives one that carries the frame status.
module websocket_frame_deframer_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wsfd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wsfd_pkg::rsp_word_type rsp_word
);
   import wsfd_pkg::*;

   // Input register: holds one accepted word until the core consumes it.
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;

   // Output register: holds one result until the response side takes it.
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;

   logic         advance;
   logic         has_result;
   rsp_word_type result;

   // The held word moves on whenever the output register is empty or is
   // being emptied in this same cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   wsfd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_word    (in_word_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (advance && has_result) begin
         out_valid_in = 1'b1;
         out_word_in  = result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // A word without payload data carries a zero data byte.
   a_empty_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.payload_present |-> rsp_word.payload_byte == 8'h00)
      else $error("payload byte nonzero on a word without payload");

   // Status is only reported on the final word of a frame.
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last_of_frame |-> rsp_word.frame_status == STATUS_OK)
      else $error("frame status reported before the end of the frame");

   // Header bytes produce nothing unless they end the frame.
   a_word_has_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.payload_present || rsp_word.last_of_frame)
      else $error("response word with neither payload nor frame end");

   // The request side is held off only by backpressure from the response side.
   a_stall_from_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without response backpressure");

endmodule

FILE: hw/rtl/wsfd_core.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer core
// Header parser state, mask key and payload counter; builds one result word.
// ----------------------------------------------------------------------------
module wsfd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  wsfd_pkg::req_word_type in_word,
   output logic                  has_result,
   output wsfd_pkg::rsp_word_type result
);
   import wsfd_pkg::*;

   localparam logic [3:0] ST_BYTE0   = 4'd0;
   localparam logic [3:0] ST_BYTE1   = 4'd1;
   localparam logic [3:0] ST_EXTHI   = 4'd2;
   localparam logic [3:0] ST_EXTLO   = 4'd3;
   localparam logic [3:0] ST_MASK0   = 4'd4;
   localparam logic [3:0] ST_MASK1   = 4'd5;
   localparam logic [3:0] ST_MASK2   = 4'd6;
   localparam logic [3:0] ST_MASK3   = 4'd7;
   localparam logic [3:0] ST_PAYLOAD = 4'd8;
   localparam logic [3:0] ST_DISCARD = 4'd9;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   logic [3:0]  stage_ff, stage_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [15:0] decl_ff, decl_in;
   logic [7:0]  mask_ff [4];
   logic [7:0]  mask_in [4];
   logic [16:0] count_ff, count_in;
   logic        unsup_ff, unsup_in;

   logic [7:0]  data;
   logic        present;
   logic [1:0]  status;

   always_comb begin
      stage_in  = stage_ff;
      opcode_in = opcode_ff;
      decl_in   = decl_ff;
      mask_in   = mask_ff;
      count_in  = count_ff;
      unsup_in  = unsup_ff;
      data      = 8'h00;
      present   = 1'b0;
      status    = STATUS_OK;

      case (stage_ff)
         ST_BYTE1: begin
            if (in_word.frame_byte[6:0] == LEN_EXT16) begin
               stage_in = ST_EXTHI;
            end else if (in_word.frame_byte[6:0] == LEN_EXT64) begin
               unsup_in = 1'b1;
               stage_in = ST_DISCARD;
            end else begin
               decl_in  = {9'd0, in_word.frame_byte[6:0]};
               stage_in = ST_MASK0;
            end
         end
         ST_EXTHI: begin
            decl_in  = {in_word.frame_byte, 8'h00};
            stage_in = ST_EXTLO;
         end
         ST_EXTLO: begin
            decl_in  = {decl_ff[15:8], in_word.frame_byte};
            stage_in = ST_MASK0;
         end
         ST_MASK0, ST_MASK1, ST_MASK2, ST_MASK3: begin
            mask_in[stage_ff[1:0]] = in_word.frame_byte;
            stage_in = stage_ff + 4'd1;
         end
         ST_PAYLOAD: begin
            data    = in_word.frame_byte ^ mask_ff[count_ff[1:0]];
            present = 1'b1;
            // The counter sticks at its top value, which keeps the key index at 3.
            if (count_ff != {17{1'b1}}) begin
               count_in = count_ff + 17'd1;
            end
         end
         ST_DISCARD: begin
         end
         default: begin
            opcode_in = in_word.frame_byte[3:0];
            stage_in  = ST_BYTE1;
         end
      endcase

      if (in_word.frame_end) begin
         if (unsup_in) begin
            status = STATUS_UNSUPPORTED;
         end else if (stage_in < ST_PAYLOAD) begin
            status = STATUS_TRUNCATED;
         end else if (count_in != {1'b0, decl_in}) begin
            status = STATUS_MISMATCH;
         end
         stage_in = ST_BYTE0;
         count_in = 17'd0;
         unsup_in = 1'b0;
      end
   end

   assign has_result             = present | in_word.frame_end;
   assign result.payload_byte    = data;
   assign result.payload_present = present;
   assign result.frame_opcode    = opcode_in;
   assign result.last_of_frame   = in_word.frame_end;
   assign result.frame_status    = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= ST_BYTE0;
         opcode_ff <= 4'd0;
         decl_ff   <= 16'd0;
         count_ff  <= 17'd0;
         unsup_ff  <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            mask_ff[i] <= 8'h00;
         end
      end else if (step) begin
         stage_ff  <= stage_in;
         opcode_ff <= opcode_in;
         decl_ff   <= decl_in;
         count_ff  <= count_in;
         unsup_ff  <= unsup_in;
         mask_ff   <= mask_in;
      end
   end

endmodule
